@@ rtl/core/bffa_pkg.sv @@
// Shared types, codes and defaults of the bitmap first-free allocator.
package bffa_pkg;

	localparam int MAX_ENTRIES_DEF = 4096;
	localparam int WORD_BITS_DEF   = 32;

	localparam int CMD_W    = 2;
	localparam int INDEX_W  = 12;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 13;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

	localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MARK_USED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// How a request is handled once taken
	typedef enum logic [1:0] {
		KIND_SCAN,
		KIND_MARK,
		KIND_IMMED
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DIV,
		S_MARK_RD,
		S_MARK_WR,
		S_RESULT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic req_ready;
		logic take;
		logic clr_step;
		logic scan_rd;
		logic scan_chk;
		logic div_step;
		logic mark_rd;
		logic mark_wr;
		logic rsp_load;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic  req_valid;
		kind_t kind;
		logic  clr_last;
		logic  found;
		logic  scan_last;
		logic  rsp_free;
	} sts_t;

endpackage

@@ rtl/core/bffa_if.sv @@
// Request, response and configuration channel interfaces of the allocator.
interface bffa_req_if;
	logic                          valid;
	logic                          ready;
	logic [bffa_pkg::CMD_W-1:0]    command;
	logic [bffa_pkg::INDEX_W-1:0]  index;

	modport source (output valid, output command, output index, input ready);
	modport sink (input valid, input command, input index, output ready);
endinterface

interface bffa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bffa_pkg::STATUS_W-1:0] status;
	logic [bffa_pkg::INDEX_W-1:0]  granted_index;

	modport source (output valid, output status, output granted_index, input ready);
	modport sink (input valid, input status, input granted_index, output ready);
endinterface

interface bffa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bffa_pkg::LIMIT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/bitmap_first_free_allocator_unit.sv @@
// Top level of the bitmap first-free allocator: controller plus datapath.
// After reset a clearing pass zeroes all MAP_WORDS map words (128 default), one word a cycle.
// Allocate: the scan reads one RAM word a cycle and stops at the first word with a clear
//   bit below the limit or at the last word. Mark: reciprocal index split, read, write-back.
// Rejected requests go straight to the result state. One request at a time; the next
//   is taken while a finished result still waits in the output register.
module bitmap_first_free_allocator_unit #(
	parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bffa_req_if.sink   req,
	bffa_rsp_if.source rsp,
	bffa_cfg_if.sink   cfg
);

	// Commands toward the datapath and the status it reports back
	bffa_pkg::ctl_t ctl;
	bffa_pkg::sts_t sts;

	// Sequence the clear sweep, then each request: scan, index split, read-modify-write, result
	bffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Hold the limit register, bitmap RAM, scan logic, divider and output register
	bffa_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

@@ rtl/core/bffa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bffa_ram #(
	parameter int W = 32,
	parameter int D = 128
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                       wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                       rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/bffa_ctrl.sv @@
// Controller state machine of the allocator.
module bffa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  bffa_pkg::sts_t  sts,
	output bffa_pkg::ctl_t  ctl
);

	bffa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bffa_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = bffa_pkg::S_IDLE;
			end
			bffa_pkg::S_IDLE: begin
				if (sts.req_valid) begin
					unique case (sts.kind)
						bffa_pkg::KIND_SCAN: state_d = bffa_pkg::S_SCAN_RD;
						bffa_pkg::KIND_MARK: state_d = bffa_pkg::S_DIV;
						default:             state_d = bffa_pkg::S_RESULT;
					endcase
				end
			end
			bffa_pkg::S_SCAN_RD: state_d = bffa_pkg::S_SCAN_CHK;
			bffa_pkg::S_SCAN_CHK: begin
				if (sts.found || sts.scan_last) state_d = bffa_pkg::S_RESULT;
			end
			bffa_pkg::S_DIV:     state_d = bffa_pkg::S_MARK_RD;
			bffa_pkg::S_MARK_RD: state_d = bffa_pkg::S_MARK_WR;
			bffa_pkg::S_MARK_WR: state_d = bffa_pkg::S_RESULT;
			bffa_pkg::S_RESULT: begin
				if (sts.rsp_free) state_d = bffa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			bffa_pkg::S_CLEAR:    ctl.clr_step = 1'b1;
			bffa_pkg::S_IDLE: begin
				ctl.req_ready = 1'b1;
				ctl.take      = sts.req_valid;
			end
			bffa_pkg::S_SCAN_RD:  ctl.scan_rd  = 1'b1;
			bffa_pkg::S_SCAN_CHK: ctl.scan_chk = 1'b1;
			bffa_pkg::S_DIV:      ctl.div_step = 1'b1;
			bffa_pkg::S_MARK_RD:  ctl.mark_rd  = 1'b1;
			bffa_pkg::S_MARK_WR:  ctl.mark_wr  = 1'b1;
			bffa_pkg::S_RESULT:   ctl.rsp_load = sts.rsp_free;
		endcase
	end

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |=> state_q != bffa_pkg::S_IDLE)
		else $error("taken request did not start work");

	a_one_map_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.clr_step, ctl.scan_chk, ctl.mark_wr, ctl.take}))
		else $error("more than one map operation in a cycle");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bffa_pkg::S_RESULT && !sts.rsp_free) |=> state_q == bffa_pkg::S_RESULT)
		else $error("result dropped while output busy");

endmodule

@@ rtl/core/bffa_dp.sv @@
// Datapath of the allocator: limit register, bitmap RAM, scan, index divider, result.
module bffa_dp #(
	parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	bffa_req_if.sink       req,
	bffa_rsp_if.source     rsp,
	bffa_cfg_if.sink       cfg,
	input  bffa_pkg::ctl_t ctl,
	output bffa_pkg::sts_t sts
);

	localparam int MAP_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int IDX_W     = $clog2(MAX_ENTRIES);
	localparam int RW        = $clog2(WORD_BITS);
	localparam int NW_A      = $clog2(MAX_ENTRIES + WORD_BITS + 1);
	localparam int NW        = (NW_A > bffa_pkg::LIMIT_W) ? NW_A : bffa_pkg::LIMIT_W;
	localparam int GW        = (NW > bffa_pkg::INDEX_W) ? NW : bffa_pkg::INDEX_W;
	// Reciprocal of the word size, exact for every index below 2**IDX_W
	localparam int SH        = IDX_W + RW;
	localparam int RECIP_W   = IDX_W + 2;
	localparam int PW        = IDX_W + RECIP_W;
	localparam int XW        = IDX_W + RW + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << SH) + WORD_BITS - 1) / WORD_BITS);

	logic [bffa_pkg::LIMIT_W-1:0]  limit_q;
	logic [bffa_pkg::CMD_W-1:0]    cmd_q;
	logic [AW-1:0]                 addr_q;
	logic [NW-1:0]                 base_q;
	logic [IDX_W-1:0]              idx_q;
	logic [AW-1:0]                 quo_q;
	logic [RW-1:0]                 rem_q;
	logic [bffa_pkg::STATUS_W-1:0] pend_status_q;
	logic [bffa_pkg::INDEX_W-1:0]  pend_grant_q;
	logic                          rsp_valid_q;
	logic [bffa_pkg::STATUS_W-1:0] rsp_status_q;
	logic [bffa_pkg::INDEX_W-1:0]  rsp_grant_q;

	logic [NW-1:0]                 lim;
	logic                          idx_ok;
	bffa_pkg::kind_t               kind;
	logic [bffa_pkg::STATUS_W-1:0] take_status;
	logic [WORD_BITS-1:0]          rd_data;
	logic [NW-1:0]                 remaining;
	logic [WORD_BITS-1:0]          valid_mask;
	logic [WORD_BITS-1:0]          avail;
	logic [WORD_BITS-1:0]          pick;
	logic [RW-1:0]                 bidx;
	logic                          found;
	logic [NW-1:0]                 next_base;
	logic                          scan_last;
	logic [NW-1:0]                 grant_full;
	logic [GW-1:0]                 grant_ext;
	logic [PW-1:0]                 quo_prod;
	logic [XW-1:0]                 rem_full;
	logic [AW-1:0]                 q_addr;
	logic [WORD_BITS-1:0]          bit_mask;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [WORD_BITS-1:0]          ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic                          rsp_free;

	// Saturate the configured limit at the map capacity
	assign lim = (NW'(limit_q) > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(limit_q);
	assign idx_ok = NW'(req.index) < lim;

	always_comb begin
		priority if (req.command == bffa_pkg::CMD_ALLOC) begin
			kind        = (lim == '0) ? bffa_pkg::KIND_IMMED : bffa_pkg::KIND_SCAN;
			take_status = bffa_pkg::ST_FULL;
		end else if (req.command == bffa_pkg::CMD_MARK_USED ||
		             req.command == bffa_pkg::CMD_MARK_FREE) begin
			kind        = idx_ok ? bffa_pkg::KIND_MARK : bffa_pkg::KIND_IMMED;
			take_status = idx_ok ? bffa_pkg::ST_DONE : bffa_pkg::ST_RANGE;
		end else begin
			kind        = bffa_pkg::KIND_IMMED;
			take_status = bffa_pkg::ST_RANGE;
		end
	end

	// Word scan: mask off bits at or above the limit, pick the lowest clear bit
	assign remaining = lim - base_q;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			valid_mask[b] = remaining > NW'(b);
		end
	end

	assign avail = ~rd_data & valid_mask;
	assign pick  = avail & (~avail + WORD_BITS'(1));
	assign found = |avail;

	always_comb begin
		bidx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			bidx = bidx | (pick[b] ? RW'(b) : RW'(0));
		end
	end

	assign next_base  = base_q + NW'(WORD_BITS);
	assign scan_last  = next_base >= lim;
	assign grant_full = base_q + NW'(bidx);
	assign grant_ext  = GW'(grant_full);

	// Split the index into word address (registered in S_DIV) and bit position (in S_MARK_RD)
	assign quo_prod = PW'(idx_q) * PW'(RECIP);
	assign rem_full = XW'(idx_q) - XW'(quo_q) * XW'(WORD_BITS);
	assign q_addr   = quo_q;
	assign bit_mask = WORD_BITS'(1) << rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bffa_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else begin
			if (ctl.take) begin
				addr_q <= '0;
			end else if (ctl.clr_step || (ctl.scan_chk && !found && !scan_last)) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q         <= req.command;
			base_q        <= '0;
			idx_q         <= IDX_W'(req.index);
			pend_status_q <= take_status;
			pend_grant_q  <= '0;
		end
		if (ctl.scan_chk && !found && !scan_last) begin
			base_q <= next_base;
		end
		if (ctl.scan_chk && found) begin
			pend_status_q <= bffa_pkg::ST_DONE;
			pend_grant_q  <= grant_ext[bffa_pkg::INDEX_W-1:0];
		end
		if (ctl.div_step) begin
			quo_q <= AW'(quo_prod >> SH);
		end
		if (ctl.mark_rd) begin
			rem_q <= RW'(rem_full);
		end
	end

	// Bitmap RAM ports
	always_comb begin
		priority if (ctl.scan_chk) begin
			ram_raddr = scan_last ? addr_q : addr_q + AW'(1);
		end else if (ctl.mark_rd) begin
			ram_raddr = q_addr;
		end else if (ctl.scan_rd) begin
			ram_raddr = addr_q;
		end else begin
			ram_raddr = addr_q;
		end
	end

	assign ram_we    = ctl.clr_step || (ctl.scan_chk && found) || ctl.mark_wr;
	assign ram_waddr = ctl.mark_wr ? q_addr : addr_q;

	always_comb begin
		priority if (ctl.clr_step) begin
			ram_wdata = '0;
		end else if (ctl.scan_chk) begin
			ram_wdata = rd_data | pick;
		end else if (cmd_q == bffa_pkg::CMD_MARK_USED) begin
			ram_wdata = rd_data | bit_mask;
		end else begin
			ram_wdata = rd_data & ~bit_mask;
		end
	end

	bffa_ram #(
		.W (WORD_BITS),
		.D (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// Output register
	assign rsp_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rsp_load) begin
			rsp_status_q <= pend_status_q;
			rsp_grant_q  <= pend_grant_q;
		end
	end

	assign req.ready         = ctl.req_ready;
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_index = rsp_grant_q;

	assign sts.req_valid = req.valid;
	assign sts.kind      = kind;
	assign sts.clr_last  = addr_q == AW'(MAP_WORDS - 1);
	assign sts.found     = found;
	assign sts.scan_last = scan_last;
	assign sts.rsp_free  = rsp_free;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rsp_load |-> (!rsp_valid_q || rsp.ready))
		else $error("result register overwritten before delivery");

	a_mark_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mark_rd |-> (32'(quo_q) < 32'(MAP_WORDS)))
		else $error("mark word address beyond map");

	a_grant_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan_chk && found) |-> (grant_full < lim))
		else $error("granted entry at or above limit");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bitmap first-free allocator unit.
module testbench;

	localparam int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF;
	// Command code with no operation behind it; the block must reject it
	localparam logic [bffa_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
	// Allocate worst case plus margin; used for the quiet tail at the end
	localparam int TAIL_CYCLES = 140;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [bffa_pkg::STATUS_W-1:0] status;
		logic [bffa_pkg::INDEX_W-1:0]  granted_index;
	} alloc_result_t;

	logic clk;
	logic arst_n;

	bffa_req_if req_bus ();
	bffa_rsp_if rsp_bus ();
	bffa_cfg_if cfg_bus ();

	bitmap_first_free_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Shadow copy of the block: usage bitmap and the entry limit register
	bit                           shadow_used [MAX_ENTRIES];
	logic [bffa_pkg::LIMIT_W-1:0] shadow_limit;

	// Results predicted at request acceptance, oldest first
	alloc_result_t pending_results [$];

	int mismatch_count;
	int sender_idle_pct;
	int receiver_stall_pct;

	// Long receiver hold-off: the test flips the toggle, the receiver process owns the count
	bit hold_off_toggle;
	int hold_off_len;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Safety net: several times the slowest legal run, clearing pass included
	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Saturate the register at the map capacity, as the hardware does
	function automatic int effective_limit();
		return (int'(shadow_limit) > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_limit);
	endfunction

	// Apply one accepted request to the shadow map and queue the result it must give
	function automatic void predict_allocation(input logic [bffa_pkg::CMD_W-1:0] cmd,
			input logic [bffa_pkg::INDEX_W-1:0] idx);
		alloc_result_t res;
		int lim;
		lim = effective_limit();
		res.status = bffa_pkg::ST_DONE;
		res.granted_index = '0;
		if (cmd == bffa_pkg::CMD_ALLOC) begin
			res.status = bffa_pkg::ST_FULL;
			for (int i = 0; i < lim; i++) begin
				if (!shadow_used[i]) begin
					shadow_used[i] = 1'b1;
					res.status = bffa_pkg::ST_DONE;
					res.granted_index = bffa_pkg::INDEX_W'(i);
					break;
				end
			end
		end else if (cmd == bffa_pkg::CMD_MARK_USED || cmd == bffa_pkg::CMD_MARK_FREE) begin
			if (int'(idx) < lim)
				shadow_used[idx] = (cmd == bffa_pkg::CMD_MARK_USED);
			else
				res.status = bffa_pkg::ST_RANGE;
		end else begin
			res.status = bffa_pkg::ST_RANGE;
		end
		pending_results.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// Check every accepted result against the oldest prediction
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", -1, rsp_bus.status);
			end else begin
				want = pending_results.pop_front();
				if (rsp_bus.status !== want.status)
					report_mismatch("status", want.status, rsp_bus.status);
				if (rsp_bus.granted_index !== want.granted_index)
					report_mismatch("granted_index", want.granted_index,
						rsp_bus.granted_index);
			end
		end
	end

	// Receiver: random stalls, plus a counted hold-off when the test asks for one
	initial begin
		bit seen;
		int left;
		seen = 1'b0;
		left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_toggle != seen) begin
				seen = hold_off_toggle;
				left = hold_off_len;
			end
			if (left > 0) begin
				left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offer one request; hold valid high after acceptance so back-to-back requests need no gap
	task automatic send_request(input logic [bffa_pkg::CMD_W-1:0] cmd,
			input logic [bffa_pkg::INDEX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid   <= 1'b1;
		req_bus.command <= cmd;
		req_bus.index   <= idx;
		do
			@(posedge clk);
		while (!req_bus.ready);
		predict_allocation(cmd, idx);
	endtask

	// Drop the request valid and wait until every predicted result has come back
	task automatic drain_results();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the entry limit; only done with the block idle
	task automatic write_entry_limit(input logic [bffa_pkg::LIMIT_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		shadow_limit = value;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 58;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 58;
			end
			default: begin
				sender_idle_pct = 22;
				receiver_stall_pct = 22;
			end
		endcase
	endtask

	// Mostly indices inside the current limit, the rest anywhere in the field
	function automatic logic [bffa_pkg::INDEX_W-1:0] pick_index();
		int lim;
		lim = effective_limit();
		if (lim > 0 && $urandom_range(99) < 80)
			return bffa_pkg::INDEX_W'($urandom_range(lim - 1));
		return bffa_pkg::INDEX_W'($urandom_range((1 << bffa_pkg::INDEX_W) - 1));
	endfunction

	// Fresh map at the reset limit: first allocations come out in order
	task automatic test_reset_map();
		set_idling(0);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		send_request(bffa_pkg::CMD_ALLOC, '1);
		send_request(bffa_pkg::CMD_ALLOC, '0);
	endtask

	// Mark used and free, including marks that change nothing and the reserved code
	task automatic test_mark_commands();
		set_idling(3);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd4095);
		send_request(bffa_pkg::CMD_MARK_FREE, 12'd1);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		send_request(bffa_pkg::CMD_MARK_FREE, 12'd0);
		send_request(bffa_pkg::CMD_MARK_FREE, 12'd0);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd2);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd2);
		send_request(CMD_RESERVED, 12'd4095);
		send_request(bffa_pkg::CMD_ALLOC, 12'd4095);
		drain_results();
	endtask

	// Tiny limit, zero limit and a limit above capacity
	task automatic test_limit_extremes();
		write_entry_limit(13'd2);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd2);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		write_entry_limit(13'd0);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd0);
		send_request(bffa_pkg::CMD_MARK_FREE, 12'd0);
		write_entry_limit(13'h1FFF);
		send_request(bffa_pkg::CMD_MARK_FREE, 12'd4095);
		send_request(bffa_pkg::CMD_MARK_USED, 12'd4095);
		send_request(bffa_pkg::CMD_ALLOC, '0);
		drain_results();
	endtask

	// Hold the output for a long stretch so the block backs up, then pause the sender
	task automatic test_input_stall();
		write_entry_limit(13'd4096);
		set_idling(0);
		hold_off_len = 300;
		hold_off_toggle = ~hold_off_toggle;
		for (int i = 0; i < 16; i++)
			send_request((i % 3 == 0) ? bffa_pkg::CMD_MARK_FREE : bffa_pkg::CMD_ALLOC,
				pick_index());
		drain_results();
		for (int i = 0; i < 8; i++)
			send_request(bffa_pkg::CMD_ALLOC, '0);
		drain_results();
	endtask

	// Random command mix over a run of limit settings and idling modes
	task automatic test_random_mix();
		logic [bffa_pkg::LIMIT_W-1:0] limits [14];
		logic [bffa_pkg::CMD_W-1:0] cmd;
		int roll;
		limits = '{13'd4096, 13'd1, 13'h1FFF, 13'd37, 13'd0, 13'd4095, 13'd64,
			13'd200, 13'd3000, 13'd33, 13'd4096, 13'd5000, 13'd2, 13'd500};
		for (int phase = 0; phase < 14; phase++) begin
			write_entry_limit(limits[phase]);
			set_idling(phase);
			for (int n = 0; n < 125; n++) begin
				roll = $urandom_range(99);
				if (roll < 45)
					cmd = bffa_pkg::CMD_ALLOC;
				else if (roll < 68)
					cmd = bffa_pkg::CMD_MARK_USED;
				else if (roll < 94)
					cmd = bffa_pkg::CMD_MARK_FREE;
				else
					cmd = CMD_RESERVED;
				send_request(cmd, pick_index());
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.command = bffa_pkg::CMD_ALLOC;
		req_bus.index = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = bffa_pkg::LIMIT_RESET;
		shadow_limit = bffa_pkg::LIMIT_RESET;
		foreach (shadow_used[i])
			shadow_used[i] = 1'b0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_toggle = 1'b0;
		hold_off_len = 0;

		// Hold reset, then release it at a falling edge
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;

		test_reset_map();
		test_mark_commands();
		test_limit_extremes();
		test_input_stall();
		test_random_mix();

		// Let anything stray surface before judging
		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
